// File: rtl/fbsm_pkg.sv
// Package for the frame buffer slot manager.
// Holds item structs, action and status codes, FSM state and control structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fbsm_pkg;

    localparam int SLOT_W = 5;

    localparam logic [3:0] ACT_SET_COUNT  = 4'd0;
    localparam logic [3:0] ACT_DEQUEUE    = 4'd1;
    localparam logic [3:0] ACT_REQUEST    = 4'd2;
    localparam logic [3:0] ACT_QUEUE      = 4'd3;
    localparam logic [3:0] ACT_ACQUIRE    = 4'd4;
    localparam logic [3:0] ACT_RELEASE    = 4'd5;
    localparam logic [3:0] ACT_CANCEL     = 4'd6;
    localparam logic [3:0] ACT_CONNECT    = 4'd7;
    localparam logic [3:0] ACT_DISCONNECT = 4'd8;
    localparam logic [3:0] ACT_ABANDON    = 4'd9;

    localparam logic [2:0] STS_OK        = 3'd0;
    localparam logic [2:0] STS_ABANDONED = 3'd1;
    localparam logic [2:0] STS_BAD_VALUE = 3'd2;
    localparam logic [2:0] STS_INVALID   = 3'd3;
    localparam logic [2:0] STS_BUSY      = 3'd4;
    localparam logic [2:0] STS_RETRY     = 3'd5;
    localparam logic [2:0] STS_EMPTY     = 3'd6;

    localparam logic [2:0] API_MIN = 3'd1;
    localparam logic [2:0] API_MAX = 3'd4;

    localparam logic       CFG_DEFAULT_WIDTH  = 1'b0;
    localparam logic       CFG_DEFAULT_HEIGHT = 1'b1;

    localparam logic [31:0] FORMAT_RGBA_8888 = 32'd1;
    localparam logic [31:0] TEX_USAGE_BIT    = 32'h0000_0100;

    typedef enum logic [1:0] {
        SL_FREE      = 2'd0,
        SL_DEQUEUED  = 2'd1,
        SL_QUEUED    = 2'd2,
        SL_RENDERING = 2'd3
    } t_slot_st;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_POST,
        ST_MEMRD,
        ST_COMMIT,
        ST_SWEEP,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [3:0]  action;
        logic [4:0]  slot_index;
        logic [5:0]  new_count;
        logic [15:0] req_width;
        logic [15:0] req_height;
        logic [31:0] req_format;
        logic [31:0] req_usage;
        logic [2:0]  api_id;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [4:0]  out_slot;
        logic        needs_realloc;
        logic [15:0] out_width;
        logic [15:0] out_height;
        logic [31:0] out_format;
        logic [31:0] out_usage;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic decode;
        logic scan;
        logic post;
        logic mem_rd;
        logic commit;
        logic sweep;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic go_scan;
        logic go_mem;
        logic go_sweep;
        logic scan_last;
        logic post_mem;
        logic post_sweep;
        logic sweep_last;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// File: rtl/fbsm_ctrl.sv
// Sequencer for the slot manager: decode, slot scan, memory read, commit, sweep.
// Depends on fbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbsm_ctrl
    import fbsm_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (i_stat.go_scan)       n_state = ST_SCAN;
                else if (i_stat.go_mem)   n_state = ST_MEMRD;
                else if (i_stat.go_sweep) n_state = ST_SWEEP;
                else                      n_state = ST_DONE;
            end
            ST_SCAN: begin
                if (i_stat.scan_last) n_state = ST_POST;
            end
            ST_POST: begin
                if (i_stat.post_mem)        n_state = ST_MEMRD;
                else if (i_stat.post_sweep) n_state = ST_SWEEP;
                else                        n_state = ST_DONE;
            end
            ST_MEMRD:  n_state = ST_COMMIT;
            ST_COMMIT: n_state = ST_DONE;
            ST_SWEEP: begin
                if (i_stat.sweep_last) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_DECODE: o_cmd.decode = 1'b1;
            ST_SCAN:   o_cmd.scan   = 1'b1;
            ST_POST:   o_cmd.post   = 1'b1;
            ST_MEMRD:  o_cmd.mem_rd = 1'b1;
            ST_COMMIT: o_cmd.commit = 1'b1;
            ST_SWEEP:  o_cmd.sweep  = 1'b1;
            ST_DONE:   o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/fbsm_dp.sv
// Datapath of the slot manager: slot table, buffer descriptor store, ready FIFO,
// configuration registers and the output register. Depends on fbsm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbsm_dp
    import fbsm_pkg::*;
#(
    parameter int NUM_SLOTS      = 32,
    parameter int MIN_SLOTS      = 3,
    parameter int MIN_UNDEQUEUED = 2
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  t_in_item    i_in_item,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  wire         i_cfg_valid,
    input  wire         i_cfg_index,
    input  wire  [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output t_out_item   o_out_item
);

    localparam int IW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int FW   = IW + 1;
    localparam int DW   = $clog2(NUM_SLOTS + 1);
    localparam int MAXC = (NUM_SLOTS > MIN_SLOTS + 1) ? NUM_SLOTS : MIN_SLOTS + 1;
    localparam int CW   = $clog2(MAXC + 1);
    localparam int SUMW = $clog2(NUM_SLOTS + MIN_UNDEQUEUED + MIN_SLOTS + 64) + 1;

    t_in_item  r_item;
    t_out_item r_res;
    logic      r_ovalid;

    t_slot_st    r_st    [NUM_SLOTS];
    logic [31:0] r_frame [NUM_SLOTS];
    logic        r_req   [NUM_SLOTS];
    logic        r_alloc [NUM_SLOTS];

    logic [15:0]       m_w    [NUM_SLOTS];
    logic [15:0]       m_h    [NUM_SLOTS];
    logic [31:0]       m_fmt  [NUM_SLOTS];
    logic [31:0]       m_use  [NUM_SLOTS];
    logic [SLOT_W-1:0] m_fifo [NUM_SLOTS];

    logic [15:0]       r_mw;
    logic [15:0]       r_mh;
    logic [31:0]       r_mf;
    logic [31:0]       r_mu;
    logic [SLOT_W-1:0] r_fq;

    logic [IW-1:0] r_head;
    logic [FW-1:0] r_fill;
    logic [31:0]   r_fcount;
    logic [CW-1:0] r_active;
    logic [31:0]   r_cur_fmt;
    logic [2:0]    r_conn;
    logic          r_aband;
    logic [15:0]   r_def_w;
    logic [15:0]   r_def_h;

    logic [IW-1:0] r_i;
    logic [DW-1:0] r_dq;
    logic [DW-1:0] r_rn;
    logic          r_fnd_v;
    logic [IW-1:0] r_fnd;
    logic [31:0]   r_fnd_fn;
    logic          r_only_rend;

    logic [3:0]    act;
    logic [IW-1:0] si;
    logic          s_act;
    logic          api_ok;
    logic          half_zero;
    logic          count_ok;
    logic [2:0]    d_st;
    logic          d_scan;
    logic          d_mem;
    logic          d_sweep;
    logic          busy;
    logic [CW-1:0] scan_lim;
    logic          scan_last;
    logic [FW-1:0] push_sum;
    logic [IW-1:0] push_addr;
    logic          q_push;
    logic [IW-1:0] head_nx;
    logic [IW-1:0] acq_slot;
    logic [15:0]   e_w;
    logic [15:0]   e_h;
    logic          upd;
    logic [31:0]   e_fmt;
    logic [31:0]   e_use;
    logic          realloc;
    logic          meta_we;

    assign act    = r_item.action;
    assign si     = IW'(r_item.slot_index);
    assign s_act  = (SUMW'(r_item.slot_index) < SUMW'(r_active)) &&
                    (SUMW'(r_item.slot_index) < SUMW'(NUM_SLOTS));
    assign api_ok = (r_item.api_id >= API_MIN) && (r_item.api_id <= API_MAX);
    assign half_zero = (r_item.req_width != 16'd0) != (r_item.req_height != 16'd0);
    assign count_ok  = !((SUMW'(r_item.new_count) > SUMW'(NUM_SLOTS)) ||
                         (SUMW'(r_item.new_count) < SUMW'(MIN_SLOTS)));

    always_comb begin
        d_st    = STS_OK;
        d_scan  = 1'b0;
        d_mem   = 1'b0;
        d_sweep = 1'b0;
        if (act == ACT_DEQUEUE) begin
            if (half_zero)    d_st = STS_BAD_VALUE;
            else if (r_aband) d_st = STS_ABANDONED;
            else              d_scan = 1'b1;
        end else if (act == ACT_ABANDON) begin
            d_sweep = 1'b1;
        end else if (act == ACT_DISCONNECT) begin
            if (!r_aband) begin
                if (api_ok && (r_conn == r_item.api_id)) d_sweep = 1'b1;
                else                                     d_st = STS_INVALID;
            end
        end else if (act > ACT_ABANDON) begin
            d_st = STS_INVALID;
        end else if (r_aband) begin
            d_st = STS_ABANDONED;
        end else begin
            case (act)
                ACT_SET_COUNT: begin
                    if (!count_ok) d_st = STS_BAD_VALUE;
                    else           d_scan = 1'b1;
                end
                ACT_REQUEST: begin
                    if (!s_act) d_st = STS_BAD_VALUE;
                end
                ACT_QUEUE: begin
                    if (!s_act || (r_st[si] != SL_DEQUEUED) || !r_req[si]) d_st = STS_INVALID;
                end
                ACT_ACQUIRE: begin
                    if (r_fill == '0) d_st = STS_EMPTY;
                    else              d_mem = 1'b1;
                end
                ACT_RELEASE: begin
                    if (!s_act || (r_st[si] != SL_RENDERING)) d_st = STS_INVALID;
                end
                ACT_CANCEL: begin
                    if (!s_act || (r_st[si] != SL_DEQUEUED)) d_st = STS_INVALID;
                end
                default: begin
                    if (!api_ok || (r_conn != 3'd0)) d_st = STS_INVALID;
                end
            endcase
        end
    end

    assign scan_lim  = (SUMW'(r_active) < SUMW'(NUM_SLOTS)) ? r_active : CW'(NUM_SLOTS);
    assign scan_last = (SUMW'(r_i) + SUMW'(1)) == SUMW'(scan_lim);
    assign busy      = (r_rn != '0) &&
                       (SUMW'(r_active) < SUMW'(r_dq) + SUMW'(1) + SUMW'(MIN_UNDEQUEUED));

    assign push_sum  = FW'(r_head) + r_fill;
    assign push_addr = (push_sum >= FW'(NUM_SLOTS)) ? IW'(push_sum - FW'(NUM_SLOTS))
                                                     : IW'(push_sum);
    assign q_push    = i_cmd.decode && (act == ACT_QUEUE) && !r_aband && (d_st == STS_OK) &&
                       (r_fill != FW'(NUM_SLOTS));
    assign head_nx   = (r_head == IW'(NUM_SLOTS - 1)) ? '0 : r_head + IW'(1);
    assign acq_slot  = IW'(r_fq);

    assign e_w     = (r_item.req_width == 16'd0) ? r_def_w : r_item.req_width;
    assign e_h     = (r_item.req_width == 16'd0) ? r_def_h : r_item.req_height;
    assign upd     = r_item.req_format != 32'd0;
    assign e_fmt   = upd ? r_item.req_format : r_cur_fmt;
    assign e_use   = r_item.req_usage | TEX_USAGE_BIT;
    assign realloc = !r_alloc[r_fnd] || (r_mw != e_w) || (r_mh != e_h) || (r_mf != e_fmt) ||
                     ((r_mu & r_item.req_usage) != r_item.req_usage);
    assign meta_we = i_cmd.commit && (act == ACT_DEQUEUE) && realloc;

    assign o_stat.go_scan    = d_scan;
    assign o_stat.go_mem     = d_mem;
    assign o_stat.go_sweep   = d_sweep;
    assign o_stat.scan_last  = scan_last;
    assign o_stat.post_mem   = (act == ACT_DEQUEUE) && !busy && r_fnd_v;
    assign o_stat.post_sweep = (act == ACT_SET_COUNT) && (r_dq == '0);
    assign o_stat.sweep_last = r_i == IW'(NUM_SLOTS - 1);
    assign o_stat.out_free   = !r_ovalid || i_out_ready;

    // descriptor store
    always_ff @(posedge i_clk) begin
        if (meta_we) begin
            m_w[r_fnd]   <= e_w;
            m_h[r_fnd]   <= e_h;
            m_fmt[r_fnd] <= e_fmt;
            m_use[r_fnd] <= e_use;
        end
        if (i_cmd.mem_rd) begin
            r_mw <= m_w[r_fnd];
            r_mh <= m_h[r_fnd];
            r_mf <= m_fmt[r_fnd];
            r_mu <= m_use[r_fnd];
        end
    end

    // ready FIFO store
    always_ff @(posedge i_clk) begin
        if (q_push) begin
            m_fifo[push_addr] <= r_item.slot_index;
        end
        if (i_cmd.mem_rd) begin
            r_fq <= m_fifo[r_head];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_st[k]    <= SL_FREE;
                r_frame[k] <= '0;
                r_req[k]   <= 1'b0;
                r_alloc[k] <= 1'b0;
            end
            r_head      <= '0;
            r_fill      <= '0;
            r_fcount    <= '0;
            r_active    <= CW'(MIN_SLOTS + 1);
            r_cur_fmt   <= FORMAT_RGBA_8888;
            r_conn      <= '0;
            r_aband     <= 1'b0;
            r_def_w     <= 16'd1;
            r_def_h     <= 16'd1;
            r_ovalid    <= 1'b0;
            r_i         <= '0;
            r_dq        <= '0;
            r_rn        <= '0;
            r_fnd_v     <= 1'b0;
            r_fnd       <= '0;
            r_fnd_fn    <= '0;
            r_only_rend <= 1'b0;
            r_res       <= '0;
            o_out_item  <= '0;
        end else begin
            if (i_cfg_valid && (i_cfg_data != 16'd0)) begin
                if (i_cfg_index == CFG_DEFAULT_WIDTH)  r_def_w <= i_cfg_data;
                if (i_cfg_index == CFG_DEFAULT_HEIGHT) r_def_h <= i_cfg_data;
            end

            if (i_cmd.load) begin
                r_res <= '0;
            end

            if (i_cmd.decode) begin
                r_res.status <= d_st;
                r_i          <= '0;
                r_dq         <= '0;
                r_rn         <= '0;
                r_fnd_v      <= 1'b0;
                r_only_rend  <= 1'b0;
                if (d_sweep) begin
                    r_head <= '0;
                    r_fill <= '0;
                    if (act == ACT_ABANDON) r_aband <= 1'b1;
                    else                    r_conn  <= '0;
                end else if ((d_st == STS_OK) && !r_aband) begin
                    case (act)
                        ACT_REQUEST: r_req[si] <= 1'b1;
                        ACT_QUEUE: begin
                            if (q_push) r_fill <= r_fill + FW'(1);
                            r_st[si]         <= SL_QUEUED;
                            r_fcount         <= r_fcount + 32'd1;
                            r_frame[si]      <= r_fcount + 32'd1;
                            r_res.out_width  <= r_def_w;
                            r_res.out_height <= r_def_h;
                        end
                        ACT_RELEASE: r_st[si] <= SL_FREE;
                        ACT_CANCEL: begin
                            r_st[si]    <= SL_FREE;
                            r_frame[si] <= '0;
                        end
                        ACT_CONNECT: begin
                            r_conn           <= r_item.api_id;
                            r_res.out_width  <= r_def_w;
                            r_res.out_height <= r_def_h;
                        end
                        default: ;
                    endcase
                end
            end

            if (i_cmd.scan) begin
                r_i <= r_i + IW'(1);
                case (r_st[r_i])
                    SL_DEQUEUED:  r_dq <= r_dq + DW'(1);
                    SL_RENDERING: r_rn <= r_rn + DW'(1);
                    SL_FREE: begin
                        if (!r_fnd_v || (r_frame[r_i] < r_fnd_fn)) begin
                            r_fnd_v  <= 1'b1;
                            r_fnd    <= r_i;
                            r_fnd_fn <= r_frame[r_i];
                        end
                    end
                    default: ;
                endcase
            end

            if (i_cmd.post) begin
                r_i <= '0;
                if (act == ACT_DEQUEUE) begin
                    if (busy)          r_res.status <= STS_BUSY;
                    else if (!r_fnd_v) r_res.status <= STS_RETRY;
                end else if (r_dq != '0) begin
                    r_res.status <= STS_INVALID;
                end else begin
                    r_only_rend <= SUMW'(r_item.new_count) >= SUMW'(r_active);
                    r_active    <= CW'(r_item.new_count);
                    r_head      <= '0;
                    r_fill      <= '0;
                end
            end

            if (i_cmd.commit) begin
                if (act == ACT_DEQUEUE) begin
                    r_st[r_fnd] <= SL_DEQUEUED;
                    if (realloc) begin
                        r_req[r_fnd]   <= 1'b0;
                        r_alloc[r_fnd] <= 1'b1;
                        if (upd) r_cur_fmt <= r_item.req_format;
                    end
                    r_res.out_slot      <= SLOT_W'(r_fnd);
                    r_res.needs_realloc <= realloc;
                    r_res.out_width     <= e_w;
                    r_res.out_height    <= e_h;
                    r_res.out_format    <= e_fmt;
                    r_res.out_usage     <= e_use;
                end else begin
                    r_head         <= head_nx;
                    r_fill         <= r_fill - FW'(1);
                    r_st[acq_slot] <= SL_RENDERING;
                    r_res.out_slot <= r_fq;
                end
            end

            if (i_cmd.sweep) begin
                r_i <= r_i + IW'(1);
                if (r_alloc[r_i] && (!r_only_rend || (r_st[r_i] == SL_RENDERING))) begin
                    r_alloc[r_i] <= 1'b0;
                    r_st[r_i]    <= SL_FREE;
                    r_frame[r_i] <= '0;
                end
            end

            if (i_cmd.out_load) begin
                r_ovalid   <= 1'b1;
                o_out_item <= r_res;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_ovalid;

endmodule
`default_nettype wire

// File: rtl/frame_buffer_slot_manager.sv
// Top level of the frame buffer slot manager.
// Instantiates fbsm_ctrl and fbsm_dp; depends on fbsm_pkg.
//
// One item is handled at a time. Dequeue walks the active slots one per cycle
// to find the oldest free one; set_count walks the active slots and then, if none
// of them is dequeued, sweeps all NUM_SLOTS entries; abandon, and disconnect from
// the connected API, sweep all NUM_SLOTS entries; acquire needs a FIFO memory
// read. The result sits in an output register, so the next item is taken while
// it waits. No clearing pass follows reset.
`timescale 1ns / 1ps
`default_nettype none
module frame_buffer_slot_manager
    import fbsm_pkg::*;
#(
    parameter int NUM_SLOTS      = 32,
    parameter int MIN_SLOTS      = 3,
    parameter int MIN_UNDEQUEUED = 2
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  t_in_item   i_in_item,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output t_out_item  o_out_item,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [15:0] i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    assign o_cfg_ready = 1'b1;

    fbsm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fbsm_dp #(
        .NUM_SLOTS      (NUM_SLOTS),
        .MIN_SLOTS      (MIN_SLOTS),
        .MIN_UNDEQUEUED (MIN_UNDEQUEUED)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != STS_OK)) |->
        ((o_out_item.out_slot == '0) && !o_out_item.needs_realloc &&
         (o_out_item.out_usage == '0) && (o_out_item.out_width == '0)))
        else $error("failed item carries payload");

    a_usage_hw: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.needs_realloc) |->
        ((o_out_item.out_usage & TEX_USAGE_BIT) == TEX_USAGE_BIT))
        else $error("allocation without hardware texture usage");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in work");

endmodule
`default_nettype wire

// File: test/tb.sv
// Testbench for frame_buffer_slot_manager: directed and random action items,
// with an item-level predictor of the slot pool checked against every result.
// Depends on fbsm_pkg and the RTL of the block.
`timescale 1ns / 1ps
module tb;
    import fbsm_pkg::*;

    localparam int NSLOT = 32;
    localparam int NMIN = 3;
    localparam int NUNDQ = 2;
    localparam int LIMIT = 1500000;

    typedef struct {
        t_in_item  item;
        t_out_item res;
    } t_job;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_item = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_item;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;

    frame_buffer_slot_manager dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // pool model
    t_slot_st    sl_st[NSLOT];
    logic [31:0] sl_frame[NSLOT];
    bit          sl_req[NSLOT];
    bit          sl_alloc[NSLOT];
    logic [15:0] sl_w[NSLOT];
    logic [15:0] sl_h[NSLOT];
    logic [31:0] sl_fmt[NSLOT];
    logic [31:0] sl_usage[NSLOT];
    logic [4:0]  rdy_fifo[NSLOT];
    int          fifo_hd, fifo_cnt, act_cnt;
    logic [31:0] frame_ctr, cur_fmt;
    logic [2:0]  conn_api;
    bit          gone;
    logic [15:0] dflt_w, dflt_h;

    t_job        pend_q[$];
    t_out_item   result_q[$];
    t_job        cur_job;
    int          errors = 0;
    int          n_items = 0;
    int          cycles = 0;

    function automatic void pool_reset();
        for (int i = 0; i < NSLOT; i++) begin
            sl_st[i] = SL_FREE;
            sl_frame[i] = '0;
            sl_req[i] = 0;
            sl_alloc[i] = 0;
        end
        fifo_hd = 0;
        fifo_cnt = 0;
        frame_ctr = '0;
        act_cnt = NMIN + 1;
        cur_fmt = FORMAT_RGBA_8888;
        conn_api = '0;
        gone = 0;
        dflt_w = 16'd1;
        dflt_h = 16'd1;
    endfunction

    function automatic void drop_slots(bit only_rend);
        for (int i = 0; i < NSLOT; i++) begin
            if (sl_alloc[i] && (!only_rend || sl_st[i] == SL_RENDERING)) begin
                sl_alloc[i] = 0;
                sl_st[i] = SL_FREE;
                sl_frame[i] = '0;
            end
        end
    endfunction

    function automatic t_out_item pool_dequeue(t_in_item it);
        t_out_item   o;
        logic [15:0] w, h;
        logic [31:0] fmt;
        int          found, ndq, nrn;
        bit          realloc;
        o = '0;
        w = it.req_width;
        h = it.req_height;
        fmt = it.req_format;
        found = -1;
        ndq = 0;
        nrn = 0;
        if ((w != 0) != (h != 0)) begin
            o.status = STS_BAD_VALUE;
            return o;
        end
        if (gone) begin
            o.status = STS_ABANDONED;
            return o;
        end
        for (int i = 0; i < act_cnt; i++) begin
            if (sl_st[i] == SL_DEQUEUED) ndq++;
            else if (sl_st[i] == SL_RENDERING) nrn++;
            else if (sl_st[i] == SL_FREE) begin
                if (found < 0 || sl_frame[i] < sl_frame[found]) found = i;
            end
        end
        if (nrn > 0 && act_cnt - (ndq + 1) < NUNDQ) begin
            o.status = STS_BUSY;
            return o;
        end
        if (found < 0) begin
            o.status = STS_RETRY;
            return o;
        end
        if (w == 0) begin
            w = dflt_w;
            h = dflt_h;
        end
        if (it.req_format == 0) fmt = cur_fmt;
        sl_st[found] = SL_DEQUEUED;
        realloc = !sl_alloc[found] || sl_w[found] != w || sl_h[found] != h ||
                  sl_fmt[found] != fmt || (sl_usage[found] & it.req_usage) != it.req_usage;
        if (realloc) begin
            sl_req[found] = 0;
            if (it.req_format != 0) cur_fmt = fmt;
            sl_alloc[found] = 1;
            sl_w[found] = w;
            sl_h[found] = h;
            sl_fmt[found] = fmt;
            sl_usage[found] = it.req_usage | TEX_USAGE_BIT;
        end
        o.status = STS_OK;
        o.out_slot = found[4:0];
        o.needs_realloc = realloc;
        o.out_width = w;
        o.out_height = h;
        o.out_format = fmt;
        o.out_usage = it.req_usage | TEX_USAGE_BIT;
        return o;
    endfunction

    function automatic t_out_item pool_step(t_in_item it);
        t_out_item o;
        int        s;
        bit        api_ok, dq_seen;
        o = '0;
        s = int'(it.slot_index);
        api_ok = it.api_id >= API_MIN && it.api_id <= API_MAX;
        o.status = STS_OK;
        if (it.action == ACT_DEQUEUE) begin
            o = pool_dequeue(it);
        end else if (it.action == ACT_ABANDON) begin
            fifo_hd = 0;
            fifo_cnt = 0;
            gone = 1;
            drop_slots(0);
        end else if (it.action == ACT_DISCONNECT) begin
            if (!gone) begin
                if (api_ok && conn_api == it.api_id) begin
                    fifo_hd = 0;
                    fifo_cnt = 0;
                    drop_slots(0);
                    conn_api = '0;
                end else o.status = STS_INVALID;
            end
        end else if (it.action > ACT_ABANDON) begin
            o.status = STS_INVALID;
        end else if (gone) begin
            o.status = STS_ABANDONED;
        end else if (it.action == ACT_SET_COUNT) begin
            dq_seen = 0;
            for (int i = 0; i < act_cnt; i++)
                if (sl_st[i] == SL_DEQUEUED) dq_seen = 1;
            if (it.new_count > NSLOT || it.new_count < NMIN) o.status = STS_BAD_VALUE;
            else if (dq_seen) o.status = STS_INVALID;
            else begin
                drop_slots(it.new_count >= act_cnt);
                act_cnt = int'(it.new_count);
                fifo_hd = 0;
                fifo_cnt = 0;
            end
        end else if (it.action == ACT_REQUEST) begin
            if (s >= act_cnt) o.status = STS_BAD_VALUE;
            else sl_req[s] = 1;
        end else if (it.action == ACT_QUEUE) begin
            if (s >= act_cnt || sl_st[s] != SL_DEQUEUED || !sl_req[s]) begin
                o.status = STS_INVALID;
            end else begin
                if (fifo_cnt < NSLOT) begin
                    rdy_fifo[(fifo_hd + fifo_cnt) % NSLOT] = s[4:0];
                    fifo_cnt++;
                end
                sl_st[s] = SL_QUEUED;
                frame_ctr = frame_ctr + 32'd1;
                sl_frame[s] = frame_ctr;
                o.out_width = dflt_w;
                o.out_height = dflt_h;
            end
        end else if (it.action == ACT_ACQUIRE) begin
            if (fifo_cnt == 0) o.status = STS_EMPTY;
            else begin
                o.out_slot = rdy_fifo[fifo_hd];
                sl_st[o.out_slot] = SL_RENDERING;
                fifo_hd = (fifo_hd + 1) % NSLOT;
                fifo_cnt--;
            end
        end else if (it.action == ACT_RELEASE) begin
            if (s >= act_cnt || sl_st[s] != SL_RENDERING) o.status = STS_INVALID;
            else sl_st[s] = SL_FREE;
        end else if (it.action == ACT_CANCEL) begin
            if (s >= act_cnt || sl_st[s] != SL_DEQUEUED) o.status = STS_INVALID;
            else begin
                sl_st[s] = SL_FREE;
                sl_frame[s] = '0;
            end
        end else begin
            if (!api_ok || conn_api != 0) o.status = STS_INVALID;
            else begin
                conn_api = it.api_id;
                o.out_width = dflt_w;
                o.out_height = dflt_h;
            end
        end
        if (o.status != STS_OK) o = '{status: o.status, default: '0};
        return o;
    endfunction

    // items are predicted in order as they are queued; the result joins the
    // expected store only when the item is accepted
    task automatic add_item(t_in_item it, output t_out_item o);
        t_job j;
        j.item = it;
        j.res = pool_step(it);
        o = j.res;
        pend_q.insert(pend_q.size(), j);
        n_items++;
    endtask

    function automatic t_in_item noise_item(logic [3:0] act);
        t_in_item     it;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(t_in_item)-1:0];
        it.action = act;
        return it;
    endfunction

    function automatic t_in_item deq_item();
        t_in_item it;
        int       r;
        it = noise_item(ACT_DEQUEUE);
        r = $urandom_range(0, 9);
        if (r < 4) begin
            it.req_width = '0;
            it.req_height = '0;
        end else if (r < 6) begin
            it.req_width = 16'd64;
            it.req_height = 16'd48;
        end else if (r < 8) begin
            it.req_width = 16'd1920;
            it.req_height = 16'd1080;
        end else if (r == 9) begin
            if ($urandom_range(0, 1)) it.req_width = '0;
            else it.req_height = '0;
        end
        r = $urandom_range(0, 7);
        if (r < 4) it.req_format = '0;
        else if (r < 6) it.req_format = 32'd1;
        else if (r == 6) it.req_format = 32'd2;
        r = $urandom_range(0, 3);
        if (r == 0) it.req_usage = '0;
        else if (r == 1) it.req_usage = TEX_USAGE_BIT;
        else if (r == 2) it.req_usage = 32'h33;
        return it;
    endfunction

    task automatic one_of(logic [3:0] act, int s);
        t_in_item  it;
        t_out_item o;
        it = noise_item(act);
        it.slot_index = s[4:0];
        add_item(it, o);
    endtask

    task automatic random_flow();
        t_in_item  it;
        t_out_item o;
        int        r, s;
        r = $urandom_range(0, 99);
        s = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 7);
        if (r < 30 || r >= 85 && r < 92) begin
            add_item(deq_item(), o);
            if (o.status == STS_OK && $urandom_range(0, 9) < 7) begin
                one_of(ACT_REQUEST, int'(o.out_slot));
                if ($urandom_range(0, 19) < 17) one_of(ACT_QUEUE, int'(o.out_slot));
            end else if (o.status == STS_OK && $urandom_range(0, 1)) begin
                one_of(ACT_CANCEL, int'(o.out_slot));
            end
        end else if (r < 42) begin
            one_of(ACT_ACQUIRE, s);
        end else if (r < 55) begin
            for (int i = 0; i < act_cnt; i++)
                if (sl_st[i] == SL_RENDERING && $urandom_range(0, 2) != 0) s = i;
            one_of(ACT_RELEASE, s);
        end else if (r < 62) begin
            one_of(ACT_REQUEST, s);
        end else if (r < 68) begin
            one_of(ACT_QUEUE, s);
        end else if (r < 72) begin
            one_of(ACT_CANCEL, s);
        end else if (r < 76) begin
            it = noise_item(ACT_SET_COUNT);
            r = $urandom_range(0, 9);
            if (r < 6) it.new_count = 6'($urandom_range(3, 8));
            else if (r == 6) it.new_count = 6'(NSLOT);
            add_item(it, o);
        end else if (r < 80) begin
            it = noise_item(ACT_CONNECT);
            if ($urandom_range(0, 2) != 0) it.api_id = 3'($urandom_range(1, 4));
            add_item(it, o);
        end else if (r < 83) begin
            it = noise_item(ACT_DISCONNECT);
            if ($urandom_range(0, 9) < 7) it.api_id = conn_api;
            add_item(it, o);
        end else if (r < 85) begin
            one_of(4'($urandom_range(10, 15)), s);
        end else begin
            one_of(ACT_ACQUIRE, s);
            for (int i = 0; i < act_cnt; i++)
                if (sl_st[i] == SL_RENDERING) s = i;
            one_of(ACT_RELEASE, s);
        end
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (val != 0) begin
            if (idx == CFG_DEFAULT_WIDTH) dflt_w = val;
            else dflt_h = val;
        end
    endtask

    task automatic drain();
        do @(posedge i_clk);
        while (pend_q.size() != 0 || i_in_valid || result_q.size() != 0);
        repeat (60) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    // driver
    int tx_cnt = 0;
    int tx_gap = 0;
    always @(posedge i_clk) begin : drive
        logic nv;
        nv = i_in_valid;
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) begin
                result_q.insert(result_q.size(), cur_job.res);
                nv = 1'b0;
                tx_cnt++;
            end
            if (!nv) begin
                if (tx_gap > 0) tx_gap--;
                else if (pend_q.size() != 0) begin
                    cur_job = pend_q.pop_front();
                    i_in_item <= cur_job.item;
                    nv = 1'b1;
                    if ((tx_cnt / 100) % 3 == 0) tx_gap = 0;
                    else case ($urandom_range(0, 99)) inside
                        [0:49]:  tx_gap = 0;
                        [50:84]: tx_gap = $urandom_range(1, 3);
                        [85:96]: tx_gap = $urandom_range(4, 20);
                        default: tx_gap = $urandom_range(50, 200);
                    endcase
                end
            end
        end
        i_in_valid <= nv;
    end

    // monitor
    int rx_cnt = 0;
    int rx_hold = 0;
    bit held = 0;
    always @(posedge i_clk) begin : monitor
        t_out_item exp_r;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                rx_cnt++;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, got %0h", $time, o_out_item);
                    errors++;
                end else begin
                    exp_r = result_q.pop_front();
                    check_field("status", exp_r.status, o_out_item.status);
                    check_field("out_slot", exp_r.out_slot, o_out_item.out_slot);
                    check_field("needs_realloc", exp_r.needs_realloc,
                                o_out_item.needs_realloc);
                    check_field("out_width", exp_r.out_width, o_out_item.out_width);
                    check_field("out_height", exp_r.out_height, o_out_item.out_height);
                    check_field("out_format", exp_r.out_format, o_out_item.out_format);
                    check_field("out_usage", exp_r.out_usage, o_out_item.out_usage);
                end
            end
            if (rx_cnt == 250 && !held) begin
                held = 1;
                rx_hold = 400;
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else if ((rx_cnt / 100) % 3 == 1) begin
                i_out_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 99) < 4) rx_hold = $urandom_range(10, 60);
                i_out_ready <= $urandom_range(0, 9) < 7;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        t_in_item  it;
        t_out_item o;
        logic [15:0] ws[6];
        logic [15:0] hs[6];
        ws = '{16'd65535, 16'd0, 16'd1, 16'd640, 16'd0, 16'd17};
        hs = '{16'd65535, 16'd0, 16'd1, 16'd480, 16'd0, 16'd9};
        pool_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_reg(CFG_DEFAULT_WIDTH, 16'd320);
        write_reg(CFG_DEFAULT_HEIGHT, 16'd240);

        // directed
        it = noise_item(ACT_CONNECT); it.api_id = 3'd0; add_item(it, o);
        it.api_id = 3'd7; add_item(it, o);
        it.api_id = API_MIN; add_item(it, o);
        it.api_id = API_MAX; add_item(it, o);
        it = deq_item(); it.req_width = 16'd5; it.req_height = '0; add_item(it, o);
        it = deq_item(); it.req_width = '0; it.req_height = '0; add_item(it, o);
        one_of(ACT_REQUEST, int'(o.out_slot));
        one_of(ACT_QUEUE, int'(o.out_slot));
        one_of(ACT_ACQUIRE, 0);
        one_of(ACT_ACQUIRE, 0);
        one_of(ACT_RELEASE, int'(o.out_slot));
        one_of(ACT_CANCEL, 31);
        one_of(ACT_REQUEST, 31);
        one_of(ACT_QUEUE, 31);
        one_of(ACT_RELEASE, 31);
        one_of(4'd15, 0);
        it = noise_item(ACT_SET_COUNT); it.new_count = 6'd2; add_item(it, o);
        it.new_count = 6'd63; add_item(it, o);
        it.new_count = 6'd32; add_item(it, o);
        it = deq_item(); it.req_width = 16'd65535; it.req_height = 16'd65535;
        it.req_format = 32'hFFFF_FFFF; it.req_usage = 32'hFFFF_FFFF; add_item(it, o);
        it = noise_item(ACT_SET_COUNT); it.new_count = 6'd3; add_item(it, o);
        one_of(ACT_CANCEL, int'(o.out_slot));
        it.new_count = 6'd3; add_item(it, o);
        it = noise_item(ACT_DISCONNECT); it.api_id = 3'd2; add_item(it, o);
        it.api_id = API_MIN; add_item(it, o);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_DEFAULT_WIDTH, (p == 4) ? 16'($urandom) : ws[p]);
            write_reg(CFG_DEFAULT_HEIGHT, (p == 4) ? 16'($urandom) : hs[p]);
            while (n_items < 25 + (p + 1) * 170) random_flow();
            drain();
        end

        one_of(ACT_ABANDON, 0);
        for (int i = 0; i < 12; i++) random_flow();
        one_of(ACT_ABANDON, 0);
        it = noise_item(ACT_DISCONNECT); add_item(it, o);
        drain();

        if (errors == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
